### design/ttup_pkg.sv
`timescale 1ns / 1ps

package ttup_pkg;

  localparam int VALUE_BITS     = 64;
  localparam int MAX_STRING_LEN = 65535;
  localparam int POS_BITS       = 16;
  localparam int BASE_BITS      = 6;
  localparam int CHAR_BITS      = 8;
  localparam int PROD_BITS      = VALUE_BITS + BASE_BITS;

  localparam logic [BASE_BITS-1:0] NOT_A_DIGIT = '1;
  localparam logic [BASE_BITS-1:0] BASE_AUTO   = BASE_BITS'(0);
  localparam logic [BASE_BITS-1:0] BASE_ONE    = BASE_BITS'(1);
  localparam logic [BASE_BITS-1:0] BASE_OCT    = BASE_BITS'(8);
  localparam logic [BASE_BITS-1:0] BASE_DEC    = BASE_BITS'(10);
  localparam logic [BASE_BITS-1:0] BASE_HEX    = BASE_BITS'(16);
  localparam logic [BASE_BITS-1:0] BASE_MAX    = BASE_BITS'(36);

  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_BITS-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_BITS-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_BITS-1:0] CH_UA_OFS = CH_UA - 8'd10;
  localparam logic [CHAR_BITS-1:0] CH_LA_OFS = CH_LA - 8'd10;

  typedef struct packed {
    logic                 blank;
    logic                 minus;
    logic                 plus;
    logic                 zero;
    logic                 x_mark;
    logic [BASE_BITS-1:0] digit;
  } char_class_t;

endpackage

### design/ttup_char_class.sv
`timescale 1ns / 1ps

module ttup_char_class (
  input  logic [ttup_pkg::CHAR_BITS-1:0] ch,
  output ttup_pkg::char_class_t          cls
);

  logic [ttup_pkg::CHAR_BITS-1:0] diff;

  always_comb begin
    diff = '0;
    cls.blank = (ch == ttup_pkg::CH_SPACE) || (ch == ttup_pkg::CH_TAB) ||
                (ch == ttup_pkg::CH_LF) || (ch == ttup_pkg::CH_VT) ||
                (ch == ttup_pkg::CH_FF) || (ch == ttup_pkg::CH_CR);
    cls.minus  = (ch == ttup_pkg::CH_MINUS);
    cls.plus   = (ch == ttup_pkg::CH_PLUS);
    cls.zero   = (ch == ttup_pkg::CH_ZERO);
    cls.x_mark = (ch == ttup_pkg::CH_LX) || (ch == ttup_pkg::CH_UX);
    cls.digit  = ttup_pkg::NOT_A_DIGIT;
    if (ch >= ttup_pkg::CH_ZERO && ch <= ttup_pkg::CH_NINE) begin
      diff = ch - ttup_pkg::CH_ZERO;
      cls.digit = diff[ttup_pkg::BASE_BITS-1:0];
    end else if (ch >= ttup_pkg::CH_UA && ch <= ttup_pkg::CH_UZ) begin
      diff = ch - ttup_pkg::CH_UA_OFS;
      cls.digit = diff[ttup_pkg::BASE_BITS-1:0];
    end else if (ch >= ttup_pkg::CH_LA && ch <= ttup_pkg::CH_LZ) begin
      diff = ch - ttup_pkg::CH_LA_OFS;
      cls.digit = diff[ttup_pkg::BASE_BITS-1:0];
    end
  end

endmodule

### design/ttup_parse_core.sv
`timescale 1ns / 1ps

module ttup_parse_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic [ttup_pkg::CHAR_BITS-1:0]      step_char,
  input  logic                                step_start,
  input  logic [ttup_pkg::BASE_BITS-1:0]      cfg_base,
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic [ttup_pkg::VALUE_BITS-1:0]     res_value,
  output logic [ttup_pkg::POS_BITS-1:0]       res_end,
  output logic                                res_over,
  output logic                                res_nodig
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEAD, PH_SIGNED, PH_ZERO, PH_PREFIX, PH_DIGITS, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {ST_NONE, ST_TAKEN, ST_OVER} status_t;

  phase_t                              phase, phase_next;
  status_t                             status, status_next;
  logic [ttup_pkg::VALUE_BITS-1:0]     acc, acc_next;
  logic                                minus, minus_next;
  logic [ttup_pkg::BASE_BITS-1:0]      base, base_next;
  logic [ttup_pkg::POS_BITS-1:0]       pos, pos_next;

  logic [ttup_pkg::POS_BITS-1:0]       pos_cur;
  logic [ttup_pkg::CHAR_BITS-1:0]      eff_char;
  ttup_pkg::char_class_t               cls;
  phase_t                              work_phase;
  logic                                do_first, do_digit, do_take, do_finish;
  logic [ttup_pkg::POS_BITS-1:0]       fin_end;
  logic [ttup_pkg::PROD_BITS-1:0]      prod;

  logic                                emit;
  logic [ttup_pkg::VALUE_BITS-1:0]     out_value;
  logic [ttup_pkg::POS_BITS-1:0]       out_end;
  logic                                out_over, out_nodig;

  assign pos_cur  = step_start ? '0 : pos;
  assign eff_char = (pos_cur >= ttup_pkg::POS_BITS'(ttup_pkg::MAX_STRING_LEN)) ? '0 : step_char;

  ttup_char_class u_class (
    .ch  (eff_char),
    .cls (cls)
  );

  always_comb begin
    phase_next  = phase;
    status_next = status;
    acc_next    = acc;
    minus_next  = minus;
    base_next   = base;
    pos_next    = pos;
    work_phase  = phase;
    do_first    = 1'b0;
    do_digit    = 1'b0;
    do_take     = 1'b0;
    do_finish   = 1'b0;
    fin_end     = pos_cur;
    prod        = '0;
    emit        = 1'b0;
    out_value   = '0;
    out_end     = '0;
    out_over    = 1'b0;
    out_nodig   = 1'b0;

    if (step_start) begin
      phase_next  = PH_LEAD;
      work_phase  = PH_LEAD;
      status_next = ST_NONE;
      acc_next    = '0;
      minus_next  = 1'b0;
      base_next   = cfg_base;
      pos_next    = '0;
    end

    if (!step_start && (phase == PH_IDLE || phase == PH_DONE)) begin
      work_phase = phase;
    end else if (step_start && (cfg_base == ttup_pkg::BASE_ONE ||
                                cfg_base > ttup_pkg::BASE_MAX)) begin
      do_finish = 1'b1;
      fin_end   = '0;
    end else begin
      pos_next = pos_cur + 1'b1;
      unique case (work_phase)
        PH_LEAD: begin
          if (cls.blank) begin
            phase_next = PH_LEAD;
          end else if (cls.minus) begin
            minus_next = 1'b1;
            phase_next = PH_SIGNED;
          end else if (cls.plus) begin
            phase_next = PH_SIGNED;
          end else begin
            do_first = 1'b1;
          end
        end
        PH_SIGNED: do_first = 1'b1;
        PH_ZERO: begin
          if (cls.x_mark) begin
            base_next  = ttup_pkg::BASE_HEX;
            phase_next = PH_PREFIX;
          end else begin
            if (base_next == ttup_pkg::BASE_AUTO) begin
              base_next = ttup_pkg::BASE_OCT;
            end
            phase_next = PH_DIGITS;
            do_digit   = 1'b1;
          end
        end
        PH_PREFIX: begin
          if (cls.digit < ttup_pkg::BASE_HEX) begin
            phase_next = PH_DIGITS;
            do_take    = 1'b1;
          end else begin
            do_finish = 1'b1;
            fin_end   = pos_cur - 1'b1;
          end
        end
        PH_DIGITS: do_digit = 1'b1;
        default: phase_next = PH_IDLE;
      endcase

      if (do_first) begin
        if (cls.zero && (base_next == ttup_pkg::BASE_AUTO ||
                         base_next == ttup_pkg::BASE_HEX)) begin
          status_next = ST_TAKEN;
          acc_next    = '0;
          phase_next  = PH_ZERO;
        end else begin
          if (base_next == ttup_pkg::BASE_AUTO) begin
            base_next = ttup_pkg::BASE_DEC;
          end
          phase_next = PH_DIGITS;
          do_digit   = 1'b1;
        end
      end

      if (do_digit) begin
        if (cls.digit < base_next) begin
          do_take = 1'b1;
        end else begin
          do_finish = 1'b1;
        end
      end

      if (do_take && status_next != ST_OVER) begin
        prod = ttup_pkg::PROD_BITS'(acc_next) * ttup_pkg::PROD_BITS'(base_next)
             + ttup_pkg::PROD_BITS'(cls.digit);
        if (prod[ttup_pkg::PROD_BITS-1:ttup_pkg::VALUE_BITS] != '0) begin
          status_next = ST_OVER;
        end else begin
          acc_next    = prod[ttup_pkg::VALUE_BITS-1:0];
          status_next = ST_TAKEN;
        end
      end
    end

    if (do_finish) begin
      emit       = 1'b1;
      phase_next = PH_DONE;
      case (status_next)
        ST_NONE: out_nodig = 1'b1;
        ST_OVER: begin
          out_value = '1;
          out_end   = fin_end;
          out_over  = 1'b1;
        end
        default: begin
          out_value = minus_next ? ('0 - acc) : acc;
          out_end   = fin_end;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      status    <= ST_NONE;
      acc       <= '0;
      minus     <= 1'b0;
      base      <= '0;
      pos       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (step) begin
        phase  <= phase_next;
        status <= status_next;
        acc    <= acc_next;
        minus  <= minus_next;
        base   <= base_next;
        pos    <= pos_next;
      end
      if (step && emit) begin
        res_valid <= 1'b1;
        res_value <= out_value;
        res_end   <= out_end;
        res_over  <= out_over;
        res_nodig <= out_nodig;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

### design/text_to_unsigned_parser.sv
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// input     in_valid / in_ready     char_in, start_req
// output    out_valid / out_ready   value, end_offset, overflowed, no_digits
// config    cfg_valid / cfg_ready   number_base
//
// One character is taken per cycle unless the output stalls; a request passes an input
// register, then the parse step: one multiply-add by the base with its overflow check.
// out_valid is registered and rises when the parse step takes the ending character.
// Reset is synchronous and sets the base register to 10 and the parser to idle.
// A stalled output holds the next character in the input register.

module text_to_unsigned_parser (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ttup_pkg::CHAR_BITS-1:0]      char_in,
  input  logic                                start_req,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ttup_pkg::VALUE_BITS-1:0]     value,
  output logic [ttup_pkg::POS_BITS-1:0]       end_offset,
  output logic                                overflowed,
  output logic                                no_digits,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ttup_pkg::BASE_BITS-1:0]      number_base
);

  logic                              s1_valid;
  logic [ttup_pkg::CHAR_BITS-1:0]    s1_char;
  logic                              s1_start;
  logic                              advance;
  logic [ttup_pkg::BASE_BITS-1:0]    base_reg;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      base_reg <= ttup_pkg::BASE_DEC;
    end else begin
      if (cfg_valid) begin
        base_reg <= number_base;
      end
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
        s1_char  <= char_in;
        s1_start <= start_req;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  ttup_parse_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .step_char  (s1_char),
    .step_start (s1_start),
    .cfg_base   (base_reg),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res_value  (value),
    .res_end    (end_offset),
    .res_over   (overflowed),
    .res_nodig  (no_digits)
  );

endmodule

### sim/tb_text_to_unsigned_parser.sv
`timescale 1ns / 1ps

module tb_text_to_unsigned_parser;
  import ttup_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned NO_DIGIT = 99;
  localparam logic [BASE_BITS-1:0] BASE_BIN = BASE_BITS'(2);
  localparam logic [BASE_BITS-1:0] BASE_TOP_CODE = '1;
  localparam logic [VALUE_BITS-1:0] ALL_ONES = '1;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_BLANKS, SCAN_SIGNED, SCAN_ZERO, SCAN_PREFIX, SCAN_DIGITS, SCAN_DONE
  } scan_phase_t;

  typedef enum logic [1:0] {ACC_EMPTY, ACC_VALID, ACC_SATURATED} acc_state_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [POS_BITS-1:0]   end_offset;
    logic                  overflowed;
    logic                  no_digits;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CHAR_BITS-1:0] char_in = '0;
  logic start_req = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [VALUE_BITS-1:0] value;
  logic [POS_BITS-1:0] end_offset;
  logic overflowed;
  logic no_digits;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [BASE_BITS-1:0] number_base = '0;

  logic [BASE_BITS-1:0] base_reg = BASE_DEC;
  scan_phase_t scan_phase = SCAN_IDLE;
  logic [VALUE_BITS-1:0] acc = '0;
  acc_state_t acc_state = ACC_EMPTY;
  logic negative = 1'b0;
  logic [BASE_BITS-1:0] radix = '0;
  logic [POS_BITS-1:0] char_idx = '0;

  parse_result_t pending_parses[$];
  int unsigned errors = 0;
  int unsigned items_fed = 0;
  int unsigned quiet_cycles = 0;
  int unsigned ready_hold = 0;
  logic calm = 1'b0;

  text_to_unsigned_parser u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_in    (char_in),
    .start_req  (start_req),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .end_offset (end_offset),
    .overflowed (overflowed),
    .no_digits  (no_digits),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .number_base(number_base)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit is_space(logic [CHAR_BITS-1:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_FF ||
           c == CH_VT;
  endfunction

  function automatic int unsigned digit_value(logic [CHAR_BITS-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
    if (c >= CH_UA && c <= CH_UZ) return c - CH_UA_OFS;
    if (c >= CH_LA && c <= CH_LZ) return c - CH_LA_OFS;
    return NO_DIGIT;
  endfunction

  function automatic void accumulate(int unsigned d);
    logic [VALUE_BITS-1:0] b;
    logic [VALUE_BITS-1:0] cutoff;
    logic [VALUE_BITS-1:0] cutlim;
    b = (radix < BASE_BIN) ? VALUE_BITS'(BASE_BIN) : VALUE_BITS'(radix);
    cutoff = ALL_ONES / b;
    cutlim = ALL_ONES % b;
    if (acc_state == ACC_SATURATED) return;
    if (acc > cutoff || (acc == cutoff && d > cutlim)) begin
      acc_state = ACC_SATURATED;
    end else begin
      acc = acc * b + d;
      acc_state = ACC_VALID;
    end
  endfunction

  function automatic void conclude(logic [POS_BITS-1:0] stop, output parse_result_t r);
    r = '0;
    case (acc_state)
      ACC_EMPTY: r.no_digits = 1'b1;
      ACC_SATURATED: begin
        r.value = ALL_ONES;
        r.end_offset = stop;
        r.overflowed = 1'b1;
      end
      default: begin
        r.value = negative ? -acc : acc;
        r.end_offset = stop;
      end
    endcase
    scan_phase = SCAN_DONE;
  endfunction

  function automatic bit digit_step(logic [CHAR_BITS-1:0] c, logic [POS_BITS-1:0] at,
                                    output parse_result_t r);
    int unsigned d;
    r = '0;
    d = digit_value(c);
    if (d < radix) begin
      accumulate(d);
      return 1'b0;
    end
    conclude(at, r);
    return 1'b1;
  endfunction

  function automatic bit parse_step(logic [CHAR_BITS-1:0] ch, logic first,
                                    output parse_result_t r);
    logic [CHAR_BITS-1:0] c;
    logic [POS_BITS-1:0] at;
    r = '0;
    c = ch;
    if (first) begin
      scan_phase = SCAN_BLANKS;
      acc = '0;
      acc_state = ACC_EMPTY;
      negative = 1'b0;
      radix = base_reg;
      char_idx = '0;
      if (radix == BASE_ONE || radix > BASE_MAX) begin
        conclude('0, r);
        return 1'b1;
      end
    end else if (scan_phase == SCAN_IDLE || scan_phase == SCAN_DONE) begin
      return 1'b0;
    end
    at = char_idx;
    if (at >= MAX_STRING_LEN) c = '0;
    char_idx = at + 1'b1;
    if (scan_phase == SCAN_BLANKS) begin
      if (is_space(c)) return 1'b0;
      if (c == CH_MINUS) begin
        negative = 1'b1;
        scan_phase = SCAN_SIGNED;
        return 1'b0;
      end
      if (c == CH_PLUS) begin
        scan_phase = SCAN_SIGNED;
        return 1'b0;
      end
      scan_phase = SCAN_SIGNED;
    end
    case (scan_phase)
      SCAN_SIGNED: begin
        if (c == CH_ZERO && (radix == BASE_AUTO || radix == BASE_HEX)) begin
          acc_state = ACC_VALID;
          acc = '0;
          scan_phase = SCAN_ZERO;
          return 1'b0;
        end
        if (radix == BASE_AUTO) radix = BASE_DEC;
        scan_phase = SCAN_DIGITS;
        return digit_step(c, at, r);
      end
      SCAN_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          radix = BASE_HEX;
          scan_phase = SCAN_PREFIX;
          return 1'b0;
        end
        if (radix == BASE_AUTO) radix = BASE_OCT;
        scan_phase = SCAN_DIGITS;
        return digit_step(c, at, r);
      end
      SCAN_PREFIX: begin
        if (digit_value(c) < 16) begin
          scan_phase = SCAN_DIGITS;
          accumulate(digit_value(c));
          return 1'b0;
        end
        conclude(at - 1'b1, r);
        return 1'b1;
      end
      SCAN_DIGITS: return digit_step(c, at, r);
      default: begin
        scan_phase = SCAN_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      ready_hold <= pick_gap();
    end else begin
      out_ready <= 1'b1;
      ready_hold <= $urandom_range(0, 30);
    end
  end

  always @(posedge clk) begin : check_result
    parse_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_parses.size() == 0) begin
        $error("result with no request waiting: value %h end_offset %0d", value, end_offset);
        errors++;
      end else begin
        want = pending_parses.pop_front();
        if (value !== want.value) begin
          $error("value: expected %h, got %h", want.value, value);
          errors++;
        end
        if (end_offset !== want.end_offset) begin
          $error("end_offset: expected %0d, got %0d", want.end_offset, end_offset);
          errors++;
        end
        if (overflowed !== want.overflowed) begin
          $error("overflowed: expected %b, got %b", want.overflowed, overflowed);
          errors++;
        end
        if (no_digits !== want.no_digits) begin
          $error("no_digits: expected %b, got %b", want.no_digits, no_digits);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("tb_text_to_unsigned_parser: errors");
    $finish;
  end

  task automatic feed_char(logic [CHAR_BITS-1:0] ch, logic first);
    int unsigned gap;
    parse_result_t r;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in <= ch;
    start_req <= first;
    do @(posedge clk); while (!in_ready);
    if (first || !(scan_phase == SCAN_IDLE || scan_phase == SCAN_DONE)) items_fed++;
    if (parse_step(ch, first, r)) pending_parses.push_back(r);
  endtask

  task automatic feed_text(string txt, logic [CHAR_BITS-1:0] term);
    for (int i = 0; i < txt.len(); i++) feed_char(txt[i], i == 0);
    feed_char(term, txt.len() == 0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_parses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(logic [BASE_BITS-1:0] b);
    drain();
    cfg_valid <= 1'b1;
    number_base <= b;
    do @(posedge clk); while (!cfg_ready);
    base_reg = b;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CHAR_BITS-1:0] blank_char();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [CHAR_BITS-1:0] digit_char(int unsigned d);
    if (d < 10) return CH_ZERO + CHAR_BITS'(d);
    if ($urandom_range(0, 1) != 0) return CH_UA_OFS + CHAR_BITS'(d);
    return CH_LA_OFS + CHAR_BITS'(d);
  endfunction

  // Number of digits of the given radix after which the value no longer fits.
  function automatic int unsigned fill_len(logic [BASE_BITS-1:0] rad);
    logic [VALUE_BITS+BASE_BITS+1:0] p;
    int unsigned n;
    p = 1;
    n = 0;
    while (p <= ALL_ONES) begin
      p = p * rad;
      n++;
    end
    return n;
  endfunction

  task automatic random_string();
    logic [CHAR_BITS-1:0] text[$];
    logic [BASE_BITS-1:0] rad;
    int unsigned r;
    int unsigned n;
    int unsigned lim;
    int unsigned d;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      n = $urandom_range(1, 8);
      repeat (n) text.push_back(CHAR_BITS'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(0, 3);
      repeat (n) text.push_back(blank_char());
      r = $urandom_range(0, 99);
      if (r < 30) text.push_back(CH_MINUS);
      else if (r < 50) text.push_back(CH_PLUS);
      if (r >= 95) text.push_back(CH_MINUS);
      rad = base_reg;
      if ((base_reg == BASE_AUTO || base_reg == BASE_HEX) && $urandom_range(0, 99) < 40) begin
        text.push_back(CH_ZERO);
        text.push_back(($urandom_range(0, 1) != 0) ? CH_LX : CH_UX);
        rad = BASE_HEX;
      end else if (base_reg == BASE_AUTO) begin
        rad = ($urandom_range(0, 99) < 25) ? BASE_OCT : BASE_DEC;
        if (rad == BASE_OCT) text.push_back(CH_ZERO);
      end
      if (rad < BASE_BIN || rad > BASE_MAX) rad = BASE_DEC;
      lim = fill_len(rad);
      r = $urandom_range(0, 99);
      if (r < 55) n = $urandom_range(1, 8);
      else if (r < 85) n = $urandom_range(lim - 2, lim + 2);
      else n = $urandom_range(0, lim + 4);
      for (int i = 0; i < n; i++) begin
        d = ($urandom_range(0, 99) < 30) ? rad - 1 : $urandom_range(0, rad - 1);
        text.push_back(digit_char(d));
      end
    end
    // Without a terminator the next string restarts the parse midway.
    r = $urandom_range(0, 99);
    if (r >= 10) text.push_back((r < 50) ? '0 : CHAR_BITS'($urandom_range(0, 255)));
    foreach (text[i]) feed_char(text[i], i == 0);
    if ($urandom_range(0, 99) < 10) begin
      n = $urandom_range(1, 3);
      repeat (n) feed_char(CHAR_BITS'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic test_reset_base();
    feed_text(" \t-12", '0);
    drain();
  endtask

  task automatic test_ignored_chars();
    feed_char("5", 1'b0);
    feed_text("7", ";");
    feed_char("8", 1'b0);
    drain();
  endtask

  task automatic test_auto_base();
    write_base(BASE_AUTO);
    feed_text("0x1F", " ");
    feed_text("\n017", "9");
    feed_text("0xg", '0);
    feed_text("+42", ",");
    drain();
  endtask

  task automatic test_hex_base();
    write_base(BASE_HEX);
    feed_text("-0XfF", '0);
    feed_text("0x", "z");
    drain();
  endtask

  task automatic test_radix_extremes();
    write_base(BASE_MAX);
    feed_text("zZ", 8'hFF);
    write_base(BASE_BIN);
    feed_text("\v+101", "2");
    drain();
  endtask

  task automatic test_invalid_base();
    write_base(BASE_ONE);
    feed_text("", "5");
    write_base(BASE_TOP_CODE);
    feed_text("", "1");
    feed_char("2", 1'b0);
    drain();
  endtask

  task automatic test_restart_and_no_digits();
    write_base(BASE_DEC);
    feed_char("1", 1'b1);
    feed_char("2", 1'b0);
    feed_text("34", '0);
    feed_text("+-", "5");
    drain();
  endtask

  task automatic test_overlong_string();
    write_base(BASE_DEC);
    calm <= 1'b1;
    feed_char(CH_SPACE, 1'b1);
    for (int i = 1; i < MAX_STRING_LEN - 2; i++) feed_char(blank_char(), 1'b0);
    feed_char("1", 1'b0);
    feed_char("2", 1'b0);
    feed_char("5", 1'b0);
    feed_char("6", 1'b0);
    drain();
    calm <= 1'b0;
  endtask

  task automatic test_random_strings();
    int unsigned goal;
    logic [BASE_BITS-1:0] b;
    int unsigned n;
    goal = items_fed + RANDOM_ITEMS;
    while (items_fed < goal) begin
      case ($urandom_range(0, 8))
        0, 7: b = BASE_AUTO;
        1: b = BASE_DEC;
        2: b = BASE_HEX;
        3: b = BASE_BIN;
        4: b = BASE_OCT;
        5: b = BASE_MAX;
        6: b = BASE_BITS'($urandom_range(BASE_BIN, BASE_MAX));
        default: b = ($urandom_range(0, 1) != 0) ? BASE_ONE :
                     BASE_BITS'($urandom_range(BASE_MAX + 1, BASE_TOP_CODE));
      endcase
      write_base(b);
      calm <= ($urandom_range(0, 3) == 0);
      n = (b == BASE_ONE || b > BASE_MAX) ? 3 : $urandom_range(6, 12);
      repeat (n) random_string();
    end
    drain();
    calm <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_base();
    test_ignored_chars();
    test_auto_base();
    test_hex_base();
    test_radix_extremes();
    test_invalid_base();
    test_restart_and_no_digits();
    test_overlong_string();
    test_random_strings();
    drain();
    if (errors == 0) begin
      $display("tb_text_to_unsigned_parser: clean");
    end else begin
      $display("tb_text_to_unsigned_parser: errors");
    end
    $finish;
  end

endmodule

### filelist.f
design/ttup_pkg.sv
design/ttup_char_class.sv
design/ttup_parse_core.sv
design/text_to_unsigned_parser.sv
sim/tb_text_to_unsigned_parser.sv
